>>> design/bju_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the rank-one jacobian update block
// no dependencies; imported by every module of the block
package bju_pkg;

	// fixed arithmetic widths, sized for the largest system (64 x 64)
	localparam int CFG_W = 7;
	localparam int ACC_W = 71;
	localparam int DEN_W = 69;
	localparam int CM_W = 56;
	localparam int NUM_W = 88;
	localparam int DVD_W = NUM_W + 16;
	localparam int QUO_W = 35;
	localparam int INC_W = 34;
	localparam int SUM_W = 36;

	localparam logic [CFG_W-1:0] DIM_RESET = 7'd16;
	localparam logic [QUO_W-1:0] INC_LIMIT = 35'h2_0000_0000;

	// register word index, taken from paddr[2]
	localparam logic REG_DIMENSION = 1'b0;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_LOAD = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_READ = 2'd1,
		ST_DONE = 2'd2,
		ST_SKIP = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic wr_jac;
		logic ld_vec;
		logic rd_item;
		logic upd_init;
		logic mac;
		logic den_en;
		logic drain_rd;
		logic corr_wr;
		logic b_rd;
		logic mul_lo;
		logic mul_hi;
		logic div_start;
		logic b_wr;
		logic res_ld;
		status_t res_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t op;
		logic last;
		logic den_zero;
		logic div_done;
	} sts_t;

endpackage

>>> design/bju_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, flags quotients too wide
// depends on bju_pkg
module bju_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bju_pkg::DVD_W-1:0] dividend,
	input  logic [bju_pkg::DEN_W-1:0] divisor,
	output logic                      done,
	output logic                      ovf,
	output logic [bju_pkg::QUO_W-1:0] quotient
);
	import bju_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q, ovf_q;
	logic [DEN_W-1:0] top_part;
	logic [DEN_W:0] trial;
	logic fits;

	assign top_part = dividend[DVD_W-1:QUO_W];
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign fits = trial >= {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (top_part >= divisor) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= 6'(QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= top_part >= divisor;
			rem_q <= top_part;
			low_q <= dividend[QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign ovf = ovf_q;
	assign quotient = quo_q;

endmodule

>>> design/bju_dp.sv
`timescale 1ns / 1ps
// datapath: jacobian and vector memories, multiply-accumulate, update arithmetic
// depends on bju_pkg and bju_div
module bju_dp #(
	parameter int MAX_DIM = 16,
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bju_pkg::cmd_t     cmd,
	input  logic [IDX_W-1:0]  row_idx,
	input  logic [IDX_W-1:0]  col_idx,
	input  logic [1:0]        op,
	input  logic [5:0]        row,
	input  logic [5:0]        col,
	input  logic [31:0]       entry_value,
	input  logic [31:0]       f_new,
	input  logic [31:0]       f_old,
	input  logic [31:0]       x_delta,
	input  logic              last,
	output bju_pkg::sts_t     sts,
	output logic [31:0]       read_value,
	output logic [1:0]        status,
	output logic              saturated
);
	import bju_pkg::*;

	localparam int JD = MAX_DIM * MAX_DIM;
	localparam int AW = (JD > 1) ? $clog2(JD) : 1;
	localparam logic [6:0] DIM_LIM = 7'(MAX_DIM);
	localparam logic [12:0] ROW_STRIDE = 13'(MAX_DIM);

	// item held for the whole operation
	op_t op_q;
	logic [5:0] row_q, col_q;
	logic [31:0] entry_q, fnew_q, fold_q, dx_q;
	logic last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op_t'(op);
			row_q <= row;
			col_q <= col;
			entry_q <= entry_value;
			fnew_q <= f_new;
			fold_q <= f_old;
			dx_q <= x_delta;
			last_q <= last;
		end
	end

	logic row_ok, item_inside;
	logic [12:0] item_lin, ij_lin;
	assign row_ok = {1'b0, row_q} < DIM_LIM;
	assign item_inside = row_ok && ({1'b0, col_q} < DIM_LIM);
	assign item_lin = 13'(row_q) * ROW_STRIDE + 13'(col_q);
	assign ij_lin = 13'(row_idx) * ROW_STRIDE + 13'(col_idx);

	// jacobian memory
	logic [31:0] jac_mem [JD];
	logic signed [31:0] jac_rd_q;
	logic jac_we, jac_re;
	logic [AW-1:0] jac_waddr, jac_raddr;
	logic [31:0] jac_wdata, new_entry;

	assign jac_we = (cmd.wr_jac && item_inside) || cmd.b_wr;
	assign jac_waddr = cmd.b_wr ? ij_lin[AW-1:0] : item_lin[AW-1:0];
	assign jac_wdata = cmd.b_wr ? new_entry : entry_q;
	assign jac_re = cmd.rd_item || cmd.mac || cmd.b_rd;
	assign jac_raddr = cmd.rd_item ? item_lin[AW-1:0] : ij_lin[AW-1:0];

	always_ff @(posedge clk) begin
		if (jac_we) begin
			jac_mem[jac_waddr] <= jac_wdata;
		end
		if (jac_re) begin
			jac_rd_q <= jac_mem[jac_raddr];
		end
	end

	// vector memories: residual difference, step, correction
	logic [32:0] diff_mem [MAX_DIM];
	logic [31:0] dx_mem [MAX_DIM];
	logic [63:0] corr_mem [MAX_DIM];
	logic signed [32:0] diff_rd_q;
	logic signed [31:0] dx_rd_q;
	logic signed [63:0] corr_rd_q;
	logic signed [63:0] corr_val;

	always_ff @(posedge clk) begin
		if (cmd.ld_vec && row_ok) begin
			diff_mem[row_q[IDX_W-1:0]] <= $signed({fnew_q[31], fnew_q})
				- $signed({fold_q[31], fold_q});
			dx_mem[row_q[IDX_W-1:0]] <= dx_q;
		end
		if (cmd.mac || cmd.b_rd) begin
			dx_rd_q <= dx_mem[col_idx];
		end
		if (cmd.drain_rd) begin
			diff_rd_q <= diff_mem[row_idx];
		end
		if (cmd.corr_wr) begin
			corr_mem[row_idx] <= corr_val;
		end
		if (cmd.b_rd) begin
			corr_rd_q <= corr_mem[row_idx];
		end
	end

	// row product pipeline valids
	logic mac_v_s1, den_v_s1, mac_v_s2, den_v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
			den_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			den_v_s2 <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.mac;
			den_v_s1 <= cmd.den_en;
			mac_v_s2 <= mac_v_s1;
			den_v_s2 <= den_v_s1;
		end
	end

	logic [31:0] dx_mag;
	logic signed [63:0] prod_s2;
	logic [63:0] sq_s2;
	assign dx_mag = dx_rd_q[31] ? (~dx_rd_q + 32'd1) : dx_rd_q;

	always_ff @(posedge clk) begin
		if (mac_v_s1) begin
			prod_s2 <= jac_rd_q * dx_rd_q;
			sq_s2 <= 64'(dx_mag) * 64'(dx_mag);
		end
	end

	// row sum of J*dx and the step norm
	logic signed [ACC_W-1:0] acc_q, acc_sh;
	logic [DEN_W-1:0] den_q;

	always_ff @(posedge clk) begin
		if (cmd.upd_init || cmd.corr_wr) begin
			acc_q <= '0;
		end else if (mac_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.upd_init) begin
			den_q <= '0;
		end else if (den_v_s2) begin
			den_q <= den_q + DEN_W'(sq_s2);
		end
	end

	// correction = diff - floor(sum / 2^16)
	assign acc_sh = acc_q >>> 16;
	assign corr_val = 64'(diff_rd_q) - acc_sh[63:0];

	// numerator |c| * |d| in two partial products
	logic [63:0] c_abs;
	logic [CM_W-1:0] c_mag;
	logic [CM_W-1:0] hi_prod;
	logic [63:0] pp_lo_q;
	logic [NUM_W-1:0] num_q;

	assign c_abs = corr_rd_q[63] ? (~corr_rd_q + 64'd1) : corr_rd_q;
	assign c_mag = c_abs[CM_W-1:0];
	assign hi_prod = CM_W'(c_mag[CM_W-1:32]) * CM_W'(dx_mag);

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			pp_lo_q <= 64'(c_mag[31:0]) * 64'(dx_mag);
		end
		if (cmd.mul_hi) begin
			num_q <= (NUM_W'(hi_prod) << 32) + NUM_W'(pp_lo_q);
		end
	end

	logic div_done, div_ovf;
	logic [QUO_W-1:0] quo;

	bju_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend({num_q, 16'b0}),
		.divisor(den_q),
		.done(div_done),
		.ovf(div_ovf),
		.quotient(quo)
	);

	// increment, new entry and clamping
	logic q_big, neg, clamp_hi, clamp_lo, clamp;
	logic [INC_W-1:0] inc_mag;
	logic signed [SUM_W-1:0] inc_pos, inc_val, new_sum;

	assign q_big = div_ovf || (quo > INC_LIMIT);
	assign inc_mag = q_big ? INC_LIMIT[INC_W-1:0] : quo[INC_W-1:0];
	assign neg = corr_rd_q[63] ^ dx_rd_q[31];
	assign inc_pos = $signed({2'b00, inc_mag});
	assign inc_val = neg ? -inc_pos : inc_pos;
	assign new_sum = SUM_W'(jac_rd_q) + inc_val;
	assign clamp_hi = new_sum > 36'sd2147483647;
	assign clamp_lo = new_sum < -36'sd2147483648;
	assign clamp = clamp_hi || clamp_lo;
	assign new_entry = clamp_hi ? 32'h7fff_ffff : (clamp_lo ? 32'h8000_0000 : new_sum[31:0]);

	logic sat_q;
	always_ff @(posedge clk) begin
		if (cmd.upd_init) begin
			sat_q <= 1'b0;
		end else if (cmd.b_wr && clamp) begin
			sat_q <= 1'b1;
		end
	end

	// result register
	logic [31:0] res_value_q;
	status_t res_status_q;
	logic res_sat_q;

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_value_q <= (cmd.res_status == ST_READ && item_inside) ? jac_rd_q : '0;
			res_status_q <= cmd.res_status;
			res_sat_q <= (cmd.res_status == ST_DONE) && (sat_q || (cmd.b_wr && clamp));
		end
	end

	assign read_value = res_value_q;
	assign status = res_status_q;
	assign saturated = res_sat_q;

	assign sts.op = op_q;
	assign sts.last = last_q;
	assign sts.den_zero = den_q == '0;
	assign sts.div_done = div_done;

endmodule

>>> design/bju_ctrl.sv
`timescale 1ns / 1ps
// controller: item sequencing and the two update sweeps over the jacobian
// depends on bju_pkg
module bju_ctrl #(
	parameter int MAX_DIM = 16,
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  logic [bju_pkg::CFG_W-1:0] dimension,
	input  bju_pkg::sts_t             sts,
	output bju_pkg::cmd_t             cmd,
	output logic [IDX_W-1:0]          row_idx,
	output logic [IDX_W-1:0]          col_idx
);
	import bju_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_EXEC   = 14'h0002,
		S_RDWAIT = 14'h0004,
		S_RESP   = 14'h0008,
		S_AMAC   = 14'h0010,
		S_ADR1   = 14'h0020,
		S_ADR2   = 14'h0040,
		S_ACORR  = 14'h0080,
		S_BRD    = 14'h0100,
		S_BMLO   = 14'h0200,
		S_BMHI   = 14'h0400,
		S_BDIVS  = 14'h0800,
		S_BDIVW  = 14'h1000,
		S_BWR    = 14'h2000
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
	logic [CFG_W-1:0] n_last;
	logic i_end, j_end;

	// last active index from the dimension register
	always_comb begin
		if (dimension == '0) begin
			n_last = '0;
		end else if (dimension > CFG_W'(MAX_DIM)) begin
			n_last = CFG_W'(MAX_DIM - 1);
		end else begin
			n_last = dimension - CFG_W'(1);
		end
	end

	assign i_end = CFG_W'(i_q) == n_last;
	assign j_end = CFG_W'(j_q) == n_last;

	// next state and commands
	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		cmd = '0;
		cmd.res_status = ST_ACCEPT;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.op)
					OP_WRITE: begin
						cmd.wr_jac = 1'b1;
						cmd.res_ld = 1'b1;
						state_d = S_RESP;
					end
					OP_LOAD: begin
						cmd.ld_vec = 1'b1;
						if (sts.last) begin
							cmd.upd_init = 1'b1;
							i_d = '0;
							j_d = '0;
							state_d = S_AMAC;
						end else begin
							cmd.res_ld = 1'b1;
							state_d = S_RESP;
						end
					end
					OP_READ: begin
						cmd.rd_item = 1'b1;
						state_d = S_RDWAIT;
					end
					default: begin
						cmd.res_ld = 1'b1;
						state_d = S_RESP;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.res_ld = 1'b1;
				cmd.res_status = ST_READ;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			S_AMAC: begin
				cmd.mac = 1'b1;
				cmd.den_en = i_q == '0;
				if (j_end) begin
					j_d = '0;
					state_d = S_ADR1;
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			S_ADR1: begin
				cmd.drain_rd = 1'b1;
				state_d = S_ADR2;
			end
			S_ADR2: begin
				state_d = S_ACORR;
			end
			S_ACORR: begin
				cmd.corr_wr = 1'b1;
				if (!i_end) begin
					i_d = i_q + IDX_W'(1);
					state_d = S_AMAC;
				end else if (sts.den_zero) begin
					cmd.res_ld = 1'b1;
					cmd.res_status = ST_SKIP;
					state_d = S_RESP;
				end else begin
					i_d = '0;
					j_d = '0;
					state_d = S_BRD;
				end
			end
			S_BRD: begin
				cmd.b_rd = 1'b1;
				state_d = S_BMLO;
			end
			S_BMLO: begin
				cmd.mul_lo = 1'b1;
				state_d = S_BMHI;
			end
			S_BMHI: begin
				cmd.mul_hi = 1'b1;
				state_d = S_BDIVS;
			end
			S_BDIVS: begin
				cmd.div_start = 1'b1;
				state_d = S_BDIVW;
			end
			S_BDIVW: begin
				if (sts.div_done) begin
					state_d = S_BWR;
				end
			end
			S_BWR: begin
				cmd.b_wr = 1'b1;
				state_d = S_BRD;
				if (!j_end) begin
					j_d = j_q + IDX_W'(1);
				end else begin
					j_d = '0;
					if (i_end) begin
						cmd.res_ld = 1'b1;
						cmd.res_status = ST_DONE;
						state_d = S_RESP;
					end else begin
						i_d = i_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_RESP;
	assign row_idx = i_q;
	assign col_idx = j_q;

endmodule

>>> design/broyden_jacobian_update_top.sv
`timescale 1ns / 1ps
// write, load and read items: one registered result per item, next item
// taken once that result is transferred; the last load runs the update:
// row sums over the jacobian first, then one divide (35-step divider) for each of the n*n
// entries. arst_n clears control and sets dimension to 16; memories hold no reset.
// depends on bju_pkg, bju_ctrl, bju_dp
module broyden_jacobian_update_top #(
	parameter int MAX_DIM = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row[5:0], col[11:6], entry_value[43:12], f_new[75:44], f_old[107:76],
	// x_delta[139:108], zero[143:140]
	input  logic [143:0] s_tdata,
	// op[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_value[31:0]
	output logic [31:0]  m_tdata,
	// status[1:0], saturated[2]
	output logic [2:0]   m_tuser
);
	import bju_pkg::*;

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	// configuration register
	logic [CFG_W-1:0] dimension_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= DIM_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_DIMENSION) begin
			dimension_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIMENSION) ? {25'b0, dimension_q} : '0;

	cmd_t cmd;
	sts_t sts;
	logic [IDX_W-1:0] row_idx, col_idx;
	logic [1:0] res_status;
	logic res_sat;

	bju_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.dimension(dimension_q),
		.sts(sts),
		.cmd(cmd),
		.row_idx(row_idx),
		.col_idx(col_idx)
	);

	bju_dp #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.row_idx(row_idx),
		.col_idx(col_idx),
		.op(s_tuser),
		.row(s_tdata[5:0]),
		.col(s_tdata[11:6]),
		.entry_value(s_tdata[43:12]),
		.f_new(s_tdata[75:44]),
		.f_old(s_tdata[107:76]),
		.x_delta(s_tdata[139:108]),
		.last(s_tlast),
		.sts(sts),
		.read_value(m_tdata),
		.status(res_status),
		.saturated(res_sat)
	);

	assign m_tuser = {res_sat, res_status};

endmodule

>>> test/bju_checker.sv
`timescale 1ns / 1ps
// transfer checker for the rank-one jacobian update block: tracks the dimension
// register, predicts one result per input transfer and compares output transfers
// depends on bju_pkg
module bju_checker #(
	parameter int MAX_DIM = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [31:0]  m_tdata,
	input  logic [2:0]   m_tuser,
	output int           errors,
	output int           pending
);
	import bju_pkg::*;

	typedef struct packed {
		logic [31:0] read_value;
		status_t     status;
		logic        saturated;
	} bju_result_t;

	// shadow copy of the block state
	logic [CFG_W-1:0]   dim_shadow;
	logic signed [31:0] jac [MAX_DIM][MAX_DIM];
	logic signed [32:0] diff_vec [MAX_DIM];
	logic signed [31:0] step_vec [MAX_DIM];
	bju_result_t        result_q [$];

	// broyden rank-one update over the active size, old jacobian for every row sum
	task automatic rank_one_update(output status_t st, output logic sat);
		int n;
		logic signed [127:0] acc;
		logic [127:0] den;
		logic [127:0] quo;
		longint corr [MAX_DIM];
		longint cv, dv, inc, nv;
		logic [63:0] cm, dm;
		n = (dim_shadow == 0) ? 1 : ((dim_shadow > MAX_DIM) ? MAX_DIM : int'(dim_shadow));
		den = '0;
		sat = 1'b0;
		for (int i = 0; i < n; i++) begin
			acc = '0;
			for (int j = 0; j < n; j++)
				acc += $signed(jac[i][j]) * $signed(step_vec[j]);
			corr[i] = longint'(diff_vec[i]) - longint'(acc >>> 16);
			dv = step_vec[i];
			dm = (dv < 0) ? -dv : dv;
			den += 128'(dm) * 128'(dm);
		end
		if (den == 0) begin
			st = ST_SKIP;
			return;
		end
		for (int i = 0; i < n; i++) begin
			cv = corr[i];
			cm = (cv < 0) ? -cv : cv;
			for (int j = 0; j < n; j++) begin
				dv = step_vec[j];
				dm = (dv < 0) ? -dv : dv;
				quo = ((128'(cm) * 128'(dm)) << 16) / den;
				if (quo > (128'(1) << 33))
					quo = 128'(1) << 33;
				inc = longint'(quo[63:0]);
				if ((cv < 0) != (dv < 0))
					inc = -inc;
				nv = longint'(jac[i][j]) + inc;
				if (nv > 64'sh7fff_ffff) begin
					nv = 64'sh7fff_ffff;
					sat = 1'b1;
				end
				if (nv < -64'sh8000_0000) begin
					nv = -64'sh8000_0000;
					sat = 1'b1;
				end
				jac[i][j] = nv[31:0];
			end
		end
		st = ST_DONE;
	endtask

	// predict one result for an accepted input item
	task automatic predict_item();
		op_t         op;
		logic [5:0]  row, col;
		bju_result_t r;
		logic        ins;
		op = op_t'(s_tuser);
		row = s_tdata[5:0];
		col = s_tdata[11:6];
		ins = (row < MAX_DIM) && (col < MAX_DIM);
		r = '{read_value: '0, status: ST_ACCEPT, saturated: 1'b0};
		case (op)
			OP_WRITE: begin
				if (ins)
					jac[row][col] = s_tdata[43:12];
			end
			OP_LOAD: begin
				if (row < MAX_DIM) begin
					diff_vec[row] = $signed(s_tdata[75:44]) - $signed(s_tdata[107:76]);
					step_vec[row] = s_tdata[139:108];
				end
				if (s_tlast)
					rank_one_update(r.status, r.saturated);
			end
			OP_READ: begin
				r.status = ST_READ;
				if (ins)
					r.read_value = jac[row][col];
			end
			default: ;
		endcase
		result_q.push_back(r);
	endtask

	// watch register writes and both channels
	always @(posedge clk or negedge arst_n) begin
		bju_result_t want;
		if (!arst_n) begin
			dim_shadow = DIM_RESET;
			errors = 0;
			pending = result_q.size();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_DIMENSION)
				dim_shadow = pwdata[CFG_W-1:0];
			if (s_tvalid && s_tready)
				predict_item();
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer data %h user %h",
						$time, m_tdata, m_tuser);
				end else begin
					want = result_q.pop_front();
					if (m_tdata !== want.read_value) begin
						errors++;
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, m_tdata);
					end
					if (m_tuser[1:0] !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, m_tuser[1:0]);
					end
					if (m_tuser[2] !== want.saturated) begin
						errors++;
						$display("%0t: saturated expected %b actual %b",
							$time, want.saturated, m_tuser[2]);
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// stimulus and verdict for the rank-one jacobian update block
// depends on bju_pkg, broyden_jacobian_update_top and bju_checker
module tb_top;
	import bju_pkg::*;

	localparam int MAX_DIM = 16;
	localparam int CYCLE_LIMIT = 1500000;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid, s_tready, s_tlast;
	logic [143:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [31:0]  m_tdata;
	logic [2:0]   m_tuser;
	int           errors, pending;
	int           cycles;
	int           burst_left;
	int           stall_left, stall_mode;
	int           act_dim;

	broyden_jacobian_update_top #(.MAX_DIM(MAX_DIM)) i_dut (.*);

	bju_checker #(.MAX_DIM(MAX_DIM)) i_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .errors, .pending
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver stall pattern: always ready, coin flip, or mostly stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			stall_mode <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(1, 60);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// one input transfer, with burst gaps before it
	task automatic send_item(op_t op, logic [5:0] row, logic [5:0] col, logic [31:0] ev,
			logic [31:0] fn, logic [31:0] fo, logic [31:0] dx, logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tlast <= last;
		s_tdata <= {4'b0, dx, fo, fn, ev, col, row};
		do @(posedge clk); while (!s_tready);
	endtask

	// sender pause until every expected result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_dimension(logic [31:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_DIMENSION, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		act_dim = (v[6:0] == 0) ? 1 : ((v[6:0] > MAX_DIM) ? MAX_DIM : int'(v[6:0]));
	endtask

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0;
					3: return 32'h0001_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
	endfunction

	// index mostly in the store, sometimes beyond it
	function automatic logic [5:0] rand_index();
		if ($urandom_range(0, 9) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, MAX_DIM - 1));
	endfunction

	task automatic random_item();
		int pick;
		logic last;
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			send_item(OP_WRITE, rand_index(), rand_index(), rand_q16(), $urandom, $urandom,
				$urandom, 1'($urandom_range(0, 1)));
		end else if (pick < 58) begin
			send_item(OP_READ, rand_index(), rand_index(), $urandom, $urandom, $urandom,
				$urandom, 1'($urandom_range(0, 1)));
		end else if (pick < 95) begin
			// loads mostly inside the active size so updates see fresh vectors
			last = (act_dim > 8) ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 11) == 0);
			send_item(OP_LOAD,
				($urandom_range(0, 9) == 0) ? rand_index() : 6'($urandom_range(0, act_dim - 1)),
				6'($urandom_range(0, 63)), $urandom, rand_q16(), rand_q16(),
				($urandom_range(0, 5) == 0) ? 32'h0 : rand_q16(), last);
		end else begin
			send_item(op_t'(2'd3), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				$urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int dims [6];
		dims = '{2, 4, 16, 0, 100, 7};
		arst_n = 1'b0;
		cycles = 0;
		burst_left = 0;
		act_dim = 16;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill every store entry so nothing undefined is ever used
		for (int r = 0; r < MAX_DIM; r++)
			for (int c = 0; c < MAX_DIM; c++)
				send_item(OP_WRITE, 6'(r), 6'(c), rand_q16(), '0, '0, '0, 1'b0);
		for (int r = 0; r < MAX_DIM; r++)
			send_item(OP_LOAD, 6'(r), 6'd0, '0, rand_q16(), rand_q16(), rand_q16(), 1'b0);

		// directed: extremes, out of range indices, unused op
		send_item(OP_WRITE, 0, 0, 32'h7fff_ffff, '0, '0, '0, 1'b0);
		send_item(OP_READ, 0, 0, '0, '0, '0, '0, 1'b0);
		send_item(OP_WRITE, 15, 15, 32'h8000_0000, '0, '0, '0, 1'b1);
		send_item(OP_READ, 15, 15, '0, '0, '0, '0, 1'b0);
		send_item(OP_WRITE, 40, 63, 32'h1234_5678, '0, '0, '0, 1'b0);
		send_item(OP_READ, 40, 63, '0, '0, '0, '0, 1'b0);
		send_item(OP_READ, 3, 20, '0, '0, '0, '0, 1'b0);
		send_item(op_t'(2'd3), 63, 63, '1, '1, '1, '1, 1'b1);
		send_item(OP_READ, 63, 0, '1, '1, '1, '1, 1'b1);

		// size one: zero denominator, ignored load that still starts, saturation
		write_dimension(32'd1);
		send_item(OP_LOAD, 0, 0, '0, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
		send_item(OP_LOAD, 50, 0, '0, 32'h7fff_ffff, 32'h0, 32'h1, 1'b1);
		send_item(OP_WRITE, 0, 0, 32'h7fff_0000, '0, '0, '0, 1'b0);
		send_item(OP_LOAD, 0, 0, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b1);
		send_item(OP_READ, 0, 0, '0, '0, '0, '0, 1'b0);
		send_item(OP_LOAD, 0, 0, '0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 1'b1);
		send_item(OP_READ, 0, 0, '0, '0, '0, '0, 1'b0);
		send_item(OP_LOAD, 0, 0, '0, 32'h8000_0000, 32'h0, 32'h8000_0000, 1'b1);
		send_item(OP_READ, 0, 0, '0, '0, '0, '0, 1'b0);

		// full size update with the vectors loaded since reset
		write_dimension(32'd127);
		send_item(OP_LOAD, 3, 0, '0, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 1'b1);
		send_item(OP_READ, 3, 3, '0, '0, '0, '0, 1'b0);

		// random phases over several sizes
		foreach (dims[k]) begin
			write_dimension(dims[k]);
			for (int i = 0; i < 80; i++) begin
				if ($urandom_range(0, 79) == 0)
					drain();
				random_item();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
